// ----- hdl/vfd_pkg.sv -----
`timescale 1ns / 1ps

package vfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 4;
    localparam int STORE_DEPTH = 8;
    localparam int BOARD_W     = 4;
    localparam int PULSE_W     = 8;
    localparam int WORD_W      = 16;
    localparam int PA_W        = 24;
    localparam int MUL_W       = 18;
    localparam int PROD_W      = WORD_W + MUL_W;
    localparam int PA_SHIFT    = 10;
    localparam int OUT_W       = 72;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'h55;
    localparam logic [BYTE_W-1:0] VITAL_TYPE  = 8'd197;
    localparam logic [BYTE_W-1:0] BOARD_LO    = 8'd10;
    localparam logic [BYTE_W-1:0] BOARD_MID   = 8'd11;
    localparam logic [BYTE_W-1:0] BOARD_HI    = 8'd12;

    // position of the last stored byte; the tail there still makes a full frame
    localparam logic [POS_W-1:0] POS_FULL = 4'd8;
    localparam logic [POS_W-1:0] POS_MAX  = 4'd9;

    // 0.1 * 133.322 * 16 * 1024, rounded to nearest
    localparam logic [MUL_W-1:0] PA_Q4_MUL = 18'd218435;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [WORD_W-1:0]  press;
        logic [WORD_W-1:0]  spo2;
        logic [PULSE_W-1:0] pulse;
        logic [BOARD_W-1:0] board;
    } vfd_rec_t;

endpackage

// ----- hdl/vital_frame_decoder.sv -----
`timescale 1ns / 1ps

// Vital-sign frame decoder. Takes one received serial byte per item on the
// slave side, one item per clock when the master side keeps up. A frame
// opens on 0xAA and closes on the next 0x55; bytes outside a frame are
// dropped, and 0xAA inside a frame is plain data. When the tail closes a
// frame of at least nine bytes whose type byte is 197 and whose board byte
// is 10, 11 or 12, one item leaves on the master side after passing the
// capture register, which takes the frame fields when the tail is accepted,
// and the output register, which takes the 16 x 18 pressure multiply. Each
// of those two stages holds one item, so tready drops only while both stages
// are full and the master side stalls. Short frames and frames with a wrong
// type or board give nothing; bytes past the eighth are not stored.
module vital_frame_decoder
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] rx_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [3:0] board_number, [11:4] pulse_rate, [27:12] spo2_tenths,
    // [43:28] pressure_tenths_mmhg, [67:44] pressure_pa_q4, [71:68] zero
    output logic [vfd_pkg::OUT_W-1:0] m_tdata
);

    import vfd_pkg::*;

    // frame tracking
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  idx;
    byte_t             bytes_reg  [STORE_DEPTH];
    byte_t             bytes_next [STORE_DEPTH];

    // capture stage
    logic              s1_valid_reg;
    vfd_rec_t          s1_rec_reg;
    vfd_rec_t          s1_rec_next;

    // output stage
    logic              out_valid_reg;
    vfd_rec_t          out_rec_reg;
    logic [PA_W-1:0]   out_pa_reg;
    logic [PROD_W-1:0] product;

    logic              in_accept;
    logic              out_free;
    logic              s1_advance;
    logic              is_tail;
    logic              frame_ok;
    byte_t             rx;

    assign rx        = s_tdata;
    assign out_free  = !out_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    // take a new byte whenever the capture stage is empty or drains this cycle
    assign s_tready  = !s1_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;
    assign is_tail   = (rx == TAIL_BYTE);
    assign idx       = pos_reg + POS_W'(1);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            bytes_next[i] = bytes_reg[i];
        end
        if (!in_frame_reg)
        begin
            // open a frame on the header, drop everything else
            if (rx == HEADER_BYTE)
            begin
                in_frame_next = 1'b1;
                pos_next      = '0;
            end
        end
        else
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (idx == POS_W'(i + 1))
                begin
                    bytes_next[i] = rx;
                end
            end
            pos_next = (idx > POS_MAX) ? POS_MAX : idx;
            if (is_tail)
            begin
                in_frame_next = 1'b0;
            end
        end
    end

    // judge the frame on the updated store, so a tail in the eighth slot counts
    assign frame_ok = in_frame_reg && is_tail && (pos_next >= POS_FULL)
                   && (bytes_next[0] == VITAL_TYPE)
                   && ((bytes_next[1] == BOARD_LO) || (bytes_next[1] == BOARD_MID)
                       || (bytes_next[1] == BOARD_HI));

    always_comb
    begin
        s1_rec_next.board = bytes_next[1][BOARD_W-1:0];
        s1_rec_next.pulse = bytes_next[3];
        s1_rec_next.spo2  = {bytes_next[5], bytes_next[4]};
        s1_rec_next.press = {bytes_next[7], bytes_next[6]};
    end

    assign product = PROD_W'(s1_rec_reg.press) * PROD_W'(PA_Q4_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_frame_reg <= in_frame_next;
                pos_reg      <= pos_next;
            end
            if (in_accept && frame_ok)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                bytes_reg[i] <= bytes_next[i];
            end
        end
        if (in_accept && frame_ok)
        begin
            s1_rec_reg <= s1_rec_next;
        end
        if (s1_advance)
        begin
            out_rec_reg <= s1_rec_reg;
            out_pa_reg  <= product[PA_SHIFT +: PA_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - PA_W - 2 * WORD_W - PULSE_W - BOARD_W){1'b0}},
                       out_pa_reg, out_rec_reg.press, out_rec_reg.spo2,
                       out_rec_reg.pulse, out_rec_reg.board};

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("frame position beyond saturation");

    a_board_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rec_reg.board == BOARD_LO[BOARD_W-1:0])
                       || (out_rec_reg.board == BOARD_MID[BOARD_W-1:0])
                       || (out_rec_reg.board == BOARD_HI[BOARD_W-1:0]))
        else $error("result with a board outside the accepted set");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && frame_ok) |=> s1_valid_reg)
        else $error("accepted frame not captured");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_frame_reg && is_tail) |=> !in_frame_reg)
        else $error("tail did not close the frame");

endmodule
